/* hdl/indexed_masked_conv2d_unit_assert.svh */
// ----------------------------------------------------------------------------
// indexed masked conv2d assertion macros
// shared property shapes for the concurrent checks of the conv2d unit
// ----------------------------------------------------------------------------
`ifndef INDEXED_MASKED_CONV2D_UNIT_ASSERT_SVH
`define INDEXED_MASKED_CONV2D_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IMC2D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define IMC2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/imc2d_pkg.sv */
// ----------------------------------------------------------------------------
// imc2d_pkg
// codes, widths and control types of the indexed masked conv2d unit
// ----------------------------------------------------------------------------
`default_nettype none

package imc2d_pkg;

  // exact q11.30 sum width
  localparam int SUM_W = 41;
  localparam int PROD_W = 32;
  localparam int SMP_W = 16;

  // config port address width (eight word registers)
  localparam int CFG_AW = 5;

  // item kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_CONV   = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_SET = 2'd1;
  localparam logic [1:0] STAT_POS = 2'd2;

  // register indexes
  localparam logic [2:0] REG_IMAGE_ROWS   = 3'd0;
  localparam logic [2:0] REG_IMAGE_COLS   = 3'd1;
  localparam logic [2:0] REG_INPUT_DEPTH  = 3'd2;
  localparam logic [2:0] REG_OUTPUT_DEPTH = 3'd3;
  localparam logic [2:0] REG_KERNEL_ROWS  = 3'd4;
  localparam logic [2:0] REG_KERNEL_COLS  = 3'd5;
  localparam logic [2:0] REG_SET_COUNT    = 3'd6;
  localparam logic [2:0] REG_SAME_PAD     = 3'd7;

  // sequencer to mac control
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* hdl/imc2d_mac.sv */
// ----------------------------------------------------------------------------
// imc2d_mac
// shared multiply-accumulate: registered 16x16 product, exact 41-bit sum
// ----------------------------------------------------------------------------
`default_nettype none

module imc2d_mac (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire imc2d_pkg::mac_ctrl_t                ctrl_i,
  input  wire logic signed [imc2d_pkg::SMP_W-1:0]  pixel_i,
  input  wire logic signed [imc2d_pkg::SMP_W-1:0]  weight_i,
  output logic signed [imc2d_pkg::SUM_W-1:0]       acc_o
);

  logic signed [imc2d_pkg::PROD_W-1:0] prod_q;
  logic                                prod_vld_q;
  logic signed [imc2d_pkg::SUM_W-1:0]  acc_d, acc_q;

  // product stage, payload only
  always_ff @(posedge clk_i) begin
    prod_q <= pixel_i * weight_i;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(imc2d_pkg::SUM_W - imc2d_pkg::PROD_W){prod_q[imc2d_pkg::PROD_W-1]}},
                       prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.valid && !ctrl_i.clear;
      acc_q      <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* hdl/indexed_masked_conv2d_unit.sv */
// ----------------------------------------------------------------------------
// indexed_masked_conv2d_unit
// stride-1 conv2d with a per-output filter set select and output mask
// ----------------------------------------------------------------------------
// usage
//   command channel: an item is taken when start is high and busy is low.
//   kind pixel or weight writes one q1.15 value into the image or weight
//   memory and gives no result; busy stays low, so loads go back to back.
//   kind conv computes one output; kind 3 is dropped.
//   result channel: done_o marks a one-cycle result beat; the receiver
//   cannot stall, so the beat must be taken in that cycle.
//   a masked conv or one with a bad position or filter set gives its beat
//   in the cycle after the accept, busy stays low.
//   a full conv walks every tap of kernel_rows x kernel_cols x input_depth
//   through one shared multiply-accumulate, one tap a cycle; the beat
//   follows the run, drain and done states, and busy is high until then.
//   taps outside the image are masked to zero.
//   config: apb writes at byte address 4*index, pready always high; write
//   only while idle.
//   reset: registers return to 64x64x16, 16 outputs, 3x3 kernel, 8 sets,
//   same padding; the memories are not cleared and must be loaded first.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_masked_conv2d_unit #(
  parameter int MAX_ROWS      = 64,
  parameter int MAX_COLS      = 64,
  parameter int MAX_IN_DEPTH  = 16,
  parameter int MAX_OUT_DEPTH = 16,
  parameter int MAX_TAPS      = 7,
  parameter int MAX_SETS      = 8
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  // command channel
  input  wire                                       start,
  output logic                                      busy,
  input  wire logic [1:0]                           kind_i,
  input  wire logic [5:0]                           row_i,
  input  wire logic [5:0]                           col_i,
  input  wire logic [3:0]                           in_channel_i,
  input  wire logic [3:0]                           out_channel_i,
  input  wire logic [2:0]                           filter_set_i,
  input  wire logic [2:0]                           tap_row_i,
  input  wire logic [2:0]                           tap_col_i,
  input  wire logic signed [imc2d_pkg::SMP_W-1:0]   sample_i,
  input  wire logic                                 enable_i,
  // result channel
  output logic                                      done_o,
  output logic signed [imc2d_pkg::SUM_W-1:0]        conv_sum_o,
  output logic [5:0]                                res_row_o,
  output logic [5:0]                                res_col_o,
  output logic [3:0]                                res_channel_o,
  output logic [1:0]                                status_o,
  // configuration port
  input  wire                                       psel,
  input  wire                                       penable,
  input  wire                                       pwrite,
  input  wire logic [imc2d_pkg::CFG_AW-1:0]         paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  `include "indexed_masked_conv2d_unit_assert.svh"

  // memory geometry
  localparam int IMG_WORDS = MAX_ROWS * MAX_COLS * MAX_IN_DEPTH;
  localparam int WGT_WORDS = MAX_SETS * MAX_TAPS * MAX_TAPS * MAX_IN_DEPTH * MAX_OUT_DEPTH;
  localparam int IAW = (IMG_WORDS > 1) ? $clog2(IMG_WORDS) : 1;
  localparam int WAW = (WGT_WORDS > 1) ? $clog2(WGT_WORDS) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0] rows_q, cols_q;
  logic [4:0] idep_q, odep_q;
  logic [2:0] kr_q, kc_q;
  logic [3:0] nsets_q;
  logic       same_q;
  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[imc2d_pkg::CFG_AW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 7'd64;
      cols_q  <= 7'd64;
      idep_q  <= 5'd16;
      odep_q  <= 5'd16;
      kr_q    <= 3'd3;
      kc_q    <= 3'd3;
      nsets_q <= 4'd8;
      same_q  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        imc2d_pkg::REG_IMAGE_ROWS:   rows_q  <= pwdata[6:0];
        imc2d_pkg::REG_IMAGE_COLS:   cols_q  <= pwdata[6:0];
        imc2d_pkg::REG_INPUT_DEPTH:  idep_q  <= pwdata[4:0];
        imc2d_pkg::REG_OUTPUT_DEPTH: odep_q  <= pwdata[4:0];
        imc2d_pkg::REG_KERNEL_ROWS:  kr_q    <= pwdata[2:0];
        imc2d_pkg::REG_KERNEL_COLS:  kc_q    <= pwdata[2:0];
        imc2d_pkg::REG_SET_COUNT:    nsets_q <= pwdata[3:0];
        imc2d_pkg::REG_SAME_PAD:     same_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback, raw values
  always_comb begin
    unique case (cfg_idx)
      imc2d_pkg::REG_IMAGE_ROWS:   prdata = 32'(rows_q);
      imc2d_pkg::REG_IMAGE_COLS:   prdata = 32'(cols_q);
      imc2d_pkg::REG_INPUT_DEPTH:  prdata = 32'(idep_q);
      imc2d_pkg::REG_OUTPUT_DEPTH: prdata = 32'(odep_q);
      imc2d_pkg::REG_KERNEL_ROWS:  prdata = 32'(kr_q);
      imc2d_pkg::REG_KERNEL_COLS:  prdata = 32'(kc_q);
      imc2d_pkg::REG_SET_COUNT:    prdata = 32'(nsets_q);
      imc2d_pkg::REG_SAME_PAD:     prdata = 32'(same_q);
      default:                     prdata = '0;
    endcase
  end

  // effective values: raw registers clamped into [1, MAX]
  logic [6:0] rows_e, cols_e;
  logic [4:0] idep_e, odep_e;
  logic [2:0] kr_e, kc_e;
  logic [3:0] nsets_e;

  always_comb begin
    rows_e  = (rows_q == '0) ? 7'd1 : ((32'(rows_q) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_q);
    cols_e  = (cols_q == '0) ? 7'd1 : ((32'(cols_q) > MAX_COLS) ? 7'(MAX_COLS) : cols_q);
    idep_e  = (idep_q == '0) ? 5'd1 :
              ((32'(idep_q) > MAX_IN_DEPTH) ? 5'(MAX_IN_DEPTH) : idep_q);
    odep_e  = (odep_q == '0) ? 5'd1 :
              ((32'(odep_q) > MAX_OUT_DEPTH) ? 5'(MAX_OUT_DEPTH) : odep_q);
    kr_e    = (kr_q == '0) ? 3'd1 : ((32'(kr_q) > MAX_TAPS) ? 3'(MAX_TAPS) : kr_q);
    kc_e    = (kc_q == '0) ? 3'd1 : ((32'(kc_q) > MAX_TAPS) ? 3'(MAX_TAPS) : kc_q);
    nsets_e = (nsets_q == '0) ? 4'd1 : ((32'(nsets_q) > MAX_SETS) ? 4'(MAX_SETS) : nsets_q);
  end

  // ---------------------------------------------------------------------------
  // command decode
  // ---------------------------------------------------------------------------
  logic [1:0] state_d, state_q;
  logic       accept, pix_ld, wgt_ld, conv_req, conv_go;
  logic       row_bad, col_bad, pos_bad, set_bad;
  logic [1:0] req_status;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign pix_ld = accept && (kind_i == imc2d_pkg::KIND_PIXEL) &&
                  (32'(row_i) < MAX_ROWS) && (32'(col_i) < MAX_COLS) &&
                  (32'(in_channel_i) < MAX_IN_DEPTH);
  assign wgt_ld = accept && (kind_i == imc2d_pkg::KIND_WEIGHT) &&
                  (32'(filter_set_i) < MAX_SETS) && (32'(tap_row_i) < MAX_TAPS) &&
                  (32'(tap_col_i) < MAX_TAPS) && (32'(in_channel_i) < MAX_IN_DEPTH) &&
                  (32'(out_channel_i) < MAX_OUT_DEPTH);
  assign conv_req = accept && (kind_i == imc2d_pkg::KIND_CONV);

  // output extent: same keeps the image size, valid shrinks by kernel - 1
  always_comb begin
    if (same_q) begin
      row_bad = {1'b0, row_i} >= rows_e;
      col_bad = {1'b0, col_i} >= cols_e;
    end else begin
      row_bad = ({2'b0, row_i} + {5'b0, kr_e}) > {1'b0, rows_e};
      col_bad = ({2'b0, col_i} + {5'b0, kc_e}) > {1'b0, cols_e};
    end
    pos_bad = row_bad || col_bad || ({1'b0, out_channel_i} >= odep_e);
    set_bad = {1'b0, filter_set_i} >= nsets_e;
    if (pos_bad) begin
      req_status = imc2d_pkg::STAT_POS;
    end else if (set_bad) begin
      req_status = imc2d_pkg::STAT_SET;
    end else begin
      req_status = imc2d_pkg::STAT_OK;
    end
  end

  // only an unmasked, error-free conv runs the tap loop
  assign conv_go = conv_req && enable_i && (req_status == imc2d_pkg::STAT_OK);

  // ---------------------------------------------------------------------------
  // tap sequencer
  // ---------------------------------------------------------------------------
  logic signed [7:0] r0_d, r0_q, c0_d, c0_q;
  logic [2:0]        set_d, set_q;
  logic [3:0]        och_d, och_q;
  logic [2:0]        a_d, a_q, b_d, b_q;
  logic [4:0]        d_d, d_q;
  logic [1:0]        drn_d, drn_q;
  logic              last_d, last_b, last_a;

  assign last_d = (d_q == (idep_e - 5'd1));
  assign last_b = (b_q == (kc_e - 3'd1));
  assign last_a = (a_q == (kr_e - 3'd1));

  always_comb begin
    state_d = state_q;
    r0_d    = r0_q;
    c0_d    = c0_q;
    set_d   = set_q;
    och_d   = och_q;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    drn_d   = drn_q;
    unique case (state_q)
      ST_IDLE: begin
        if (conv_go) begin
          state_d = ST_RUN;
          // same padding centers the window, floor(size/2) taps before
          r0_d  = same_q ? (8'({2'b0, row_i}) - 8'({5'b0, kr_e >> 1})) : 8'({2'b0, row_i});
          c0_d  = same_q ? (8'({2'b0, col_i}) - 8'({5'b0, kc_e >> 1})) : 8'({2'b0, col_i});
          set_d = filter_set_i;
          och_d = out_channel_i;
          a_d   = '0;
          b_d   = '0;
          d_d   = '0;
        end
      end
      ST_RUN: begin
        // channel innermost, then tap column, then tap row
        if (!last_d) begin
          d_d = d_q + 5'd1;
        end else begin
          d_d = '0;
          if (!last_b) begin
            b_d = b_q + 3'd1;
          end else begin
            b_d = '0;
            if (!last_a) begin
              a_d = a_q + 3'd1;
            end else begin
              state_d = ST_DRAIN;
              drn_d   = '0;
            end
          end
        end
      end
      ST_DRAIN: begin
        // read, product and accumulate stages empty out
        drn_d = drn_q + 2'd1;
        if (drn_q == 2'd2) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      d_q     <= '0;
      drn_q   <= '0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
      d_q     <= d_d;
      drn_q   <= drn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q  <= r0_d;
    c0_q  <= c0_d;
    set_q <= set_d;
    och_q <= och_d;
  end

  // ---------------------------------------------------------------------------
  // window addressing and memories
  // ---------------------------------------------------------------------------
  logic signed [7:0]               ir, ic;
  logic                            in_rng, tap_rd;
  logic [IAW-1:0]                  img_waddr, img_raddr;
  logic [WAW-1:0]                  wgt_waddr, wgt_raddr;
  logic signed [imc2d_pkg::SMP_W-1:0] img_mem [IMG_WORDS];
  logic signed [imc2d_pkg::SMP_W-1:0] wgt_mem [WGT_WORDS];
  logic signed [imc2d_pkg::SMP_W-1:0] pix_q, wgt_q;
  logic                            tap_vld_q;

  assign ir     = r0_q + $signed({5'b0, a_q});
  assign ic     = c0_q + $signed({5'b0, b_q});
  // taps outside the image read address zero and are masked out of the sum
  assign in_rng = !ir[7] && (ir < $signed({1'b0, rows_e})) &&
                  !ic[7] && (ic < $signed({1'b0, cols_e}));
  assign tap_rd = (state_q == ST_RUN);

  assign img_waddr = IAW'((32'(row_i) * MAX_COLS + 32'(col_i)) * MAX_IN_DEPTH +
                          32'(in_channel_i));
  assign wgt_waddr = WAW'((((32'(filter_set_i) * MAX_TAPS + 32'(tap_row_i)) * MAX_TAPS +
                           32'(tap_col_i)) * MAX_IN_DEPTH + 32'(in_channel_i)) *
                          MAX_OUT_DEPTH + 32'(out_channel_i));

  assign img_raddr = in_rng ?
                     IAW'((32'(ir[6:0]) * MAX_COLS + 32'(ic[6:0])) * MAX_IN_DEPTH + 32'(d_q)) :
                     '0;
  assign wgt_raddr = WAW'((((32'(set_q) * MAX_TAPS + 32'(a_q)) * MAX_TAPS + 32'(b_q)) *
                          MAX_IN_DEPTH + 32'(d_q)) * MAX_OUT_DEPTH + 32'(och_q));

  always_ff @(posedge clk_i) begin
    if (pix_ld) begin
      img_mem[img_waddr] <= sample_i;
    end
    if (tap_rd) begin
      pix_q <= img_mem[img_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wgt_ld) begin
      wgt_mem[wgt_waddr] <= sample_i;
    end
    if (tap_rd) begin
      wgt_q <= wgt_mem[wgt_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q <= 1'b0;
    end else begin
      tap_vld_q <= tap_rd && in_rng;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiply-accumulate
  // ---------------------------------------------------------------------------
  imc2d_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [imc2d_pkg::SUM_W-1:0]  acc;

  assign mac_ctrl = '{clear: conv_go, valid: tap_vld_q};

  imc2d_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .pixel_i  (pix_q),
    .weight_i (wgt_q),
    .acc_o    (acc)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic                               done_d, done_q;
  logic signed [imc2d_pkg::SUM_W-1:0] sum_d, sum_q;
  logic [5:0]                         rrow_d, rrow_q, rcol_d, rcol_q;
  logic [3:0]                         rch_d, rch_q;
  logic [1:0]                         stat_d, stat_q;

  always_comb begin
    done_d = 1'b0;
    sum_d  = sum_q;
    rrow_d = rrow_q;
    rcol_d = rcol_q;
    rch_d  = rch_q;
    stat_d = stat_q;
    if (conv_req) begin
      // echo is captured at accept for every conv
      rrow_d = row_i;
      rcol_d = col_i;
      rch_d  = out_channel_i;
      stat_d = req_status;
      sum_d  = '0;
      // masked or rejected: answer right away
      done_d = !conv_go;
    end else if (state_q == ST_DONE) begin
      done_d = 1'b1;
      sum_d  = acc;
      stat_d = imc2d_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    rrow_q <= rrow_d;
    rcol_q <= rcol_d;
    rch_q  <= rch_d;
    stat_q <= stat_d;
  end

  assign done_o        = done_q;
  assign conv_sum_o    = sum_q;
  assign res_row_o     = rrow_q;
  assign res_col_o     = rcol_q;
  assign res_channel_o = rch_q;
  assign status_o      = stat_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an error beat never carries a sum
  `IMC2D_ASSERT_IMPL(a_err_sum_zero, clk_i, rst_ni, done_o && (status_o != imc2d_pkg::STAT_OK), conv_sum_o == '0)
  // an unmasked valid conv starts the tap loop
  `IMC2D_ASSERT_NEXT(a_go_runs, clk_i, rst_ni, conv_go, state_q == ST_RUN)
  // the drain ends after the accumulate stage has settled
  `IMC2D_ASSERT_NEXT(a_drain_done, clk_i, rst_ni, (state_q == ST_DRAIN) && (drn_q == 2'd2), state_q == ST_DONE)
  // the finished sum is delivered as a beat
  `IMC2D_ASSERT_NEXT(a_done_beat, clk_i, rst_ni, state_q == ST_DONE, done_o && (status_o == imc2d_pkg::STAT_OK))

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the indexed masked conv2d unit: a queued command
// driver, a result monitor and an in-bench model of the image and weight
// memories that works out each output sum, echo and status
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int MAX_ROWS      = 64;
  localparam int MAX_COLS      = 64;
  localparam int MAX_IN_DEPTH  = 16;
  localparam int MAX_OUT_DEPTH = 16;
  localparam int MAX_TAPS      = 7;
  localparam int MAX_SETS      = 8;
  localparam int PIX_WORDS     = MAX_ROWS * MAX_COLS * MAX_IN_DEPTH;
  localparam int WGT_WORDS     = MAX_SETS * MAX_TAPS * MAX_TAPS * MAX_IN_DEPTH * MAX_OUT_DEPTH;

  // unused kind code, the block drops it
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 440;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 4_000_000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [5:0]        row;
    logic [5:0]        col;
    logic [3:0]        ich;
    logic [3:0]        och;
    logic [2:0]        fset;
    logic [2:0]        trow;
    logic [2:0]        tcol;
    logic signed [15:0] smp;
    logic              en;
  } conv_cmd_t;

  typedef struct packed {
    logic signed [imc2d_pkg::SUM_W-1:0] sum;
    logic [5:0]                         row;
    logic [5:0]                         col;
    logic [3:0]                         chan;
    logic [1:0]                         status;
  } conv_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // command channel
  logic      start = 1'b0;
  logic      busy;
  conv_cmd_t cmd_q = '0;

  // result channel
  logic                               done;
  logic signed [imc2d_pkg::SUM_W-1:0] conv_sum;
  logic [5:0]                         res_row;
  logic [5:0]                         res_col;
  logic [3:0]                         res_channel;
  logic [1:0]                         status;

  // register port
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [imc2d_pkg::CFG_AW-1:0] paddr   = '0;
  logic [31:0]                  pwdata  = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  indexed_masked_conv2d_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (cmd_q.kind),
    .row_i         (cmd_q.row),
    .col_i         (cmd_q.col),
    .in_channel_i  (cmd_q.ich),
    .out_channel_i (cmd_q.och),
    .filter_set_i  (cmd_q.fset),
    .tap_row_i     (cmd_q.trow),
    .tap_col_i     (cmd_q.tcol),
    .sample_i      (cmd_q.smp),
    .enable_i      (cmd_q.en),
    .done_o        (done),
    .conv_sum_o    (conv_sum),
    .res_row_o     (res_row),
    .res_col_o     (res_col),
    .res_channel_o (res_channel),
    .status_o      (status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  // register values as written, already cut to their widths; reset values first
  int cfg_reg [8] = '{64, 64, 16, 16, 3, 3, 8, 1};

  // model copies of the two memories, filled as load beats are accepted
  logic signed [15:0] pix_mem [PIX_WORDS];
  logic signed [15:0] wgt_mem [WGT_WORDS];

  // which entries the stimulus has already loaded, kept at queue time so that
  // no conv window ever touches an entry that was never written
  bit px_loaded [PIX_WORDS];
  bit wt_loaded [WGT_WORDS];

  conv_cmd_t    cmd_backlog [$];
  conv_result_t results_due [$];

  int               items_queued = 0;
  int               mismatches   = 0;
  int               cycle_count  = 0;
  bit               no_gaps      = 1'b0;
  bit               fill_pinned  = 1'b0;
  logic signed [15:0] fill_value = '0;

  // ---------------------------------------------------------------------------
  // geometry and register helpers shared by stimulus and prediction
  // ---------------------------------------------------------------------------
  function automatic int pix_index(int r, int c, int ch);
    return (r * MAX_COLS + c) * MAX_IN_DEPTH + ch;
  endfunction

  function automatic int wgt_index(int s, int tr, int tc, int ic, int oc);
    return (((s * MAX_TAPS + tr) * MAX_TAPS + tc) * MAX_IN_DEPTH + ic) * MAX_OUT_DEPTH + oc;
  endfunction

  // register value as the block uses it: out-of-range values are clamped
  function automatic int cfg_eff(logic [2:0] idx);
    int v;
    int lo;
    int hi;
    v  = cfg_reg[idx];
    lo = 1;
    hi = 1;
    case (idx)
      imc2d_pkg::REG_IMAGE_ROWS:   hi = MAX_ROWS;
      imc2d_pkg::REG_IMAGE_COLS:   hi = MAX_COLS;
      imc2d_pkg::REG_INPUT_DEPTH:  hi = MAX_IN_DEPTH;
      imc2d_pkg::REG_OUTPUT_DEPTH: hi = MAX_OUT_DEPTH;
      imc2d_pkg::REG_KERNEL_ROWS:  hi = MAX_TAPS;
      imc2d_pkg::REG_KERNEL_COLS:  hi = MAX_TAPS;
      imc2d_pkg::REG_SET_COUNT:    hi = MAX_SETS;
      default: begin
        lo = 0;
      end
    endcase
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // output extent; in valid mode it can be empty or negative
  function automatic void out_extent(output int orows, output int ocols);
    orows = cfg_eff(imc2d_pkg::REG_IMAGE_ROWS);
    ocols = cfg_eff(imc2d_pkg::REG_IMAGE_COLS);
    if (cfg_eff(imc2d_pkg::REG_SAME_PAD) == 0) begin
      orows = orows - cfg_eff(imc2d_pkg::REG_KERNEL_ROWS) + 1;
      ocols = ocols - cfg_eff(imc2d_pkg::REG_KERNEL_COLS) + 1;
    end
  endfunction

  // first tap row or column of the window: centred in same mode
  function automatic int window_start(int pos, int k);
    return (cfg_eff(imc2d_pkg::REG_SAME_PAD) != 0) ? pos - k / 2 : pos;
  endfunction

  // position errors win over a bad filter set
  function automatic logic [1:0] conv_status(logic [5:0] row, logic [5:0] col,
                                             logic [3:0] och, logic [2:0] fset);
    int orows;
    int ocols;
    out_extent(orows, ocols);
    if (int'(row) >= orows || int'(col) >= ocols ||
        int'(och) >= cfg_eff(imc2d_pkg::REG_OUTPUT_DEPTH))
      return imc2d_pkg::STAT_POS;
    if (int'(fset) >= cfg_eff(imc2d_pkg::REG_SET_COUNT))
      return imc2d_pkg::STAT_SET;
    return imc2d_pkg::STAT_OK;
  endfunction

  // ---------------------------------------------------------------------------
  // prediction: applies one accepted beat to the model
  // ---------------------------------------------------------------------------
  function automatic void conv_unit_step(conv_cmd_t c);
    conv_result_t r;
    longint       acc;
    int           rows;
    int           cols;
    int           idep;
    int           kr;
    int           kc;
    int           r0;
    int           c0;
    int           ir;
    int           ic;
    int           a;
    int           b;
    int           d;
    case (c.kind)
      imc2d_pkg::KIND_PIXEL: begin
        pix_mem[pix_index(c.row, c.col, c.ich)] = c.smp;
      end
      imc2d_pkg::KIND_WEIGHT: begin
        // taps beyond the largest kernel miss the memory and are dropped
        if (c.trow < MAX_TAPS && c.tcol < MAX_TAPS)
          wgt_mem[wgt_index(c.fset, c.trow, c.tcol, c.ich, c.och)] = c.smp;
      end
      imc2d_pkg::KIND_CONV: begin
        rows = cfg_eff(imc2d_pkg::REG_IMAGE_ROWS);
        cols = cfg_eff(imc2d_pkg::REG_IMAGE_COLS);
        idep = cfg_eff(imc2d_pkg::REG_INPUT_DEPTH);
        kr   = cfg_eff(imc2d_pkg::REG_KERNEL_ROWS);
        kc   = cfg_eff(imc2d_pkg::REG_KERNEL_COLS);
        r0   = window_start(c.row, kr);
        c0   = window_start(c.col, kc);
        acc  = 0;
        r.status = conv_status(c.row, c.col, c.och, c.fset);
        if (r.status == imc2d_pkg::STAT_OK && c.en) begin
          for (a = 0; a < kr; a++) begin
            ir = r0 + a;
            if (ir < 0 || ir >= rows) continue;
            for (b = 0; b < kc; b++) begin
              ic = c0 + b;
              if (ic < 0 || ic >= cols) continue;
              for (d = 0; d < idep; d++)
                acc += longint'(pix_mem[pix_index(ir, ic, d)]) *
                       longint'(wgt_mem[wgt_index(c.fset, a, b, d, c.och)]);
            end
          end
        end
        r.sum  = acc[imc2d_pkg::SUM_W-1:0];
        r.row  = c.row;
        r.col  = c.col;
        r.chan = c.och;
        results_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: holds a beat until busy is low, then takes the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : cmd_driver
    conv_cmd_t nxt;
    logic      go;
    nxt = cmd_q;
    go  = start;
    if (!rst_ni) begin
      go = 1'b0;
    end else begin
      if (start && !busy) begin
        conv_unit_step(cmd_q);
        go = 1'b0;
      end
      // a random gap with a chance of about one in ten unless a gap-free stretch runs
      if (!go && cmd_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= 10)) begin
        nxt = cmd_backlog.pop_front();
        go  = 1'b1;
      end
    end
    start <= go;
    cmd_q <= nxt;
  end

  // ---------------------------------------------------------------------------
  // result monitor: every done beat must match the oldest expected result
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_monitor
    conv_result_t want;
    if (rst_ni && done === 1'b1) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual sum %0d row %0d col %0d",
                 $time, conv_sum, res_row, res_col);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("conv_sum", want.sum, conv_sum);
        check_field("res_row", want.row, res_row);
        check_field("res_col", want.col, res_col);
        check_field("res_channel", want.chan, res_channel);
        check_field("status", want.status, status);
      end
    end
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indexed_masked_conv2d_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // setup beat then access beat; the register takes the value on the access edge
  task automatic apb_write(logic [2:0] idx, int val);
    int w;
    case (idx) inside
      imc2d_pkg::REG_IMAGE_ROWS, imc2d_pkg::REG_IMAGE_COLS:     w = 7;
      imc2d_pkg::REG_INPUT_DEPTH, imc2d_pkg::REG_OUTPUT_DEPTH:  w = 5;
      imc2d_pkg::REG_KERNEL_ROWS, imc2d_pkg::REG_KERNEL_COLS:   w = 3;
      imc2d_pkg::REG_SET_COUNT:                                 w = 4;
      default:                                                  w = 1;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_reg[idx] = val & ((1 << w) - 1);
  endtask

  task automatic write_config(int rows, int cols, int idep, int odep,
                              int kr, int kc, int sets, int same);
    apb_write(imc2d_pkg::REG_IMAGE_ROWS, rows);
    apb_write(imc2d_pkg::REG_IMAGE_COLS, cols);
    apb_write(imc2d_pkg::REG_INPUT_DEPTH, idep);
    apb_write(imc2d_pkg::REG_OUTPUT_DEPTH, odep);
    apb_write(imc2d_pkg::REG_KERNEL_ROWS, kr);
    apb_write(imc2d_pkg::REG_KERNEL_COLS, kc);
    apb_write(imc2d_pkg::REG_SET_COUNT, sets);
    apb_write(imc2d_pkg::REG_SAME_PAD, same);
  endtask

  // wait until the block has nothing in hand, checked mid-cycle
  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || start || results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_sample();
    if (fill_pinned) return fill_value;
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(4))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return -16'sd1;
        3:       return 16'sd1;
        default: return 16'sd0;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic conv_cmd_t random_cmd();
    conv_cmd_t c;
    c.kind = 2'($urandom_range(3));
    c.row  = 6'($urandom_range(63));
    c.col  = 6'($urandom_range(63));
    c.ich  = 4'($urandom_range(15));
    c.och  = 4'($urandom_range(15));
    c.fset = 3'($urandom_range(7));
    c.trow = 3'($urandom_range(7));
    c.tcol = 3'($urandom_range(7));
    c.smp  = 16'($urandom);
    c.en   = 1'($urandom_range(1));
    return c;
  endfunction

  // queue one beat and note what it loads; dropped beats are not counted
  function automatic void queue_cmd(conv_cmd_t c);
    cmd_backlog.push_back(c);
    case (c.kind)
      imc2d_pkg::KIND_PIXEL: begin
        px_loaded[pix_index(c.row, c.col, c.ich)] = 1'b1;
        items_queued++;
      end
      imc2d_pkg::KIND_WEIGHT: begin
        if (c.trow < MAX_TAPS && c.tcol < MAX_TAPS) begin
          wt_loaded[wgt_index(c.fset, c.trow, c.tcol, c.ich, c.och)] = 1'b1;
          items_queued++;
        end
      end
      imc2d_pkg::KIND_CONV: items_queued++;
      default: ;
    endcase
  endfunction

  // load every pixel and weight the window reads that has never been written
  function automatic void load_window(int row, int col, int fset, int och);
    conv_cmd_t lc;
    int        kr;
    int        kc;
    int        r0;
    int        c0;
    int        ir;
    int        ic;
    int        a;
    int        b;
    int        d;
    kr = cfg_eff(imc2d_pkg::REG_KERNEL_ROWS);
    kc = cfg_eff(imc2d_pkg::REG_KERNEL_COLS);
    r0 = window_start(row, kr);
    c0 = window_start(col, kc);
    for (a = 0; a < kr; a++) begin
      ir = r0 + a;
      if (ir < 0 || ir >= cfg_eff(imc2d_pkg::REG_IMAGE_ROWS)) continue;
      for (b = 0; b < kc; b++) begin
        ic = c0 + b;
        if (ic < 0 || ic >= cfg_eff(imc2d_pkg::REG_IMAGE_COLS)) continue;
        for (d = 0; d < cfg_eff(imc2d_pkg::REG_INPUT_DEPTH); d++) begin
          if (!px_loaded[pix_index(ir, ic, d)]) begin
            lc      = random_cmd();
            lc.kind = imc2d_pkg::KIND_PIXEL;
            lc.row  = 6'(ir);
            lc.col  = 6'(ic);
            lc.ich  = 4'(d);
            lc.smp  = pick_sample();
            queue_cmd(lc);
          end
          if (!wt_loaded[wgt_index(fset, a, b, d, och)]) begin
            lc      = random_cmd();
            lc.kind = imc2d_pkg::KIND_WEIGHT;
            lc.fset = 3'(fset);
            lc.trow = 3'(a);
            lc.tcol = 3'(b);
            lc.ich  = 4'(d);
            lc.och  = 4'(och);
            lc.smp  = pick_sample();
            queue_cmd(lc);
          end
        end
      end
    end
  endfunction

  function automatic void queue_conv(int row, int col, int och, int fset, bit en);
    conv_cmd_t c;
    c      = random_cmd();
    c.kind = imc2d_pkg::KIND_CONV;
    c.row  = 6'(row);
    c.col  = 6'(col);
    c.och  = 4'(och);
    c.fset = 3'(fset);
    c.en   = en;
    if (en && conv_status(c.row, c.col, c.och, c.fset) == imc2d_pkg::STAT_OK)
      load_window(row, col, fset, och);
    queue_cmd(c);
  endfunction

  // mostly small images and shallow depth so full convs stay short
  task automatic random_config();
    int rows;
    int cols;
    int idep;
    int odep;
    int kr;
    int kc;
    bit big;
    big  = ($urandom_range(9) == 0);
    rows = big ? $urandom_range(1, 64) : $urandom_range(1, 8);
    cols = big ? $urandom_range(1, 64) : $urandom_range(1, 8);
    if ($urandom_range(19) == 0) rows = $urandom_range(1) ? 0 : $urandom_range(65, 127);
    if ($urandom_range(19) == 0) cols = $urandom_range(1) ? 0 : $urandom_range(65, 127);
    odep = ($urandom_range(19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
    kr   = $urandom_range(7);
    kc   = $urandom_range(7);
    case ($urandom_range(19))
      0: idep = 0;
      1: begin
        // deep input only with a point kernel
        idep = $urandom_range(16, 31);
        kr   = $urandom_range(1);
        kc   = $urandom_range(1);
      end
      default: idep = $urandom_range(1, 4);
    endcase
    write_config(rows, cols, idep, odep, kr, kc, $urandom_range(15), $urandom_range(1));
  endtask

  task automatic random_phase();
    conv_cmd_t c;
    int        target;
    int        orows;
    int        ocols;
    int        row;
    int        col;
    int        och;
    int        fset;
    int        pick;
    random_config();
    target = items_queued + $urandom_range(30, 70);
    while (items_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // mostly legal positions, sets and channels so full sums dominate
        out_extent(orows, ocols);
        row  = (orows > 0 && $urandom_range(99) < 85) ? $urandom_range(orows - 1)
                                                      : $urandom_range(63);
        col  = (ocols > 0 && $urandom_range(99) < 85) ? $urandom_range(ocols - 1)
                                                      : $urandom_range(63);
        och  = ($urandom_range(99) < 85) ?
               $urandom_range(cfg_eff(imc2d_pkg::REG_OUTPUT_DEPTH) - 1) : $urandom_range(15);
        fset = ($urandom_range(99) < 85) ?
               $urandom_range(cfg_eff(imc2d_pkg::REG_SET_COUNT) - 1) : $urandom_range(7);
        queue_conv(row, col, och, fset, $urandom_range(99) < 80);
      end else if (pick < 85) begin
        // overwrite inside the current image and filter bank
        c      = random_cmd();
        c.kind = $urandom_range(1) ? imc2d_pkg::KIND_PIXEL : imc2d_pkg::KIND_WEIGHT;
        c.row  = 6'($urandom_range(cfg_eff(imc2d_pkg::REG_IMAGE_ROWS) - 1));
        c.col  = 6'($urandom_range(cfg_eff(imc2d_pkg::REG_IMAGE_COLS) - 1));
        c.ich  = 4'($urandom_range(cfg_eff(imc2d_pkg::REG_INPUT_DEPTH) - 1));
        c.och  = 4'($urandom_range(cfg_eff(imc2d_pkg::REG_OUTPUT_DEPTH) - 1));
        c.fset = 3'($urandom_range(cfg_eff(imc2d_pkg::REG_SET_COUNT) - 1));
        c.trow = 3'($urandom_range(cfg_eff(imc2d_pkg::REG_KERNEL_ROWS) - 1));
        c.tcol = 3'($urandom_range(cfg_eff(imc2d_pkg::REG_KERNEL_COLS) - 1));
        c.smp  = pick_sample();
        queue_cmd(c);
      end else if (pick < 95) begin
        // load anywhere, taps of 7 included
        c      = random_cmd();
        c.kind = $urandom_range(1) ? imc2d_pkg::KIND_PIXEL : imc2d_pkg::KIND_WEIGHT;
        queue_cmd(c);
      end else begin
        c      = random_cmd();
        c.kind = KIND_SPARE;
        queue_cmd(c);
      end
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    conv_cmd_t c;
    int        phase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: masked convs read nothing, plus a spare kind and two
    // weight loads that miss the memory through a tap of 7
    queue_conv(63, 63, 15, 7, 1'b0);
    queue_conv(0, 0, 0, 0, 1'b0);
    c      = random_cmd();
    c.kind = KIND_SPARE;
    queue_cmd(c);
    c      = random_cmd();
    c.kind = imc2d_pkg::KIND_WEIGHT;
    c.trow = 3'd7;
    queue_cmd(c);
    c.trow = 3'd0;
    c.tcol = 3'd7;
    queue_cmd(c);
    wait_quiet();

    // largest kernel, centred window clipped at both far and near corners,
    // with full-scale samples to give the largest products
    write_config(64, 64, 1, 16, 7, 7, 8, 1);
    fill_pinned = 1'b1;
    fill_value  = 16'sh8000;
    queue_conv(63, 63, 15, 7, 1'b1);
    fill_value  = 16'sh7fff;
    queue_conv(0, 63, 0, 0, 1'b1);
    fill_pinned = 1'b0;
    queue_conv(31, 31, 8, 3, 1'b1);
    wait_quiet();

    // valid window the size of the image: one output, then each error
    write_config(7, 7, 1, 1, 7, 7, 1, 0);
    queue_conv(0, 0, 0, 0, 1'b1);
    queue_conv(1, 0, 0, 0, 1'b1);
    queue_conv(0, 0, 1, 0, 1'b1);
    queue_conv(0, 0, 0, 1, 1'b1);
    queue_conv(0, 1, 1, 1, 1'b0);
    wait_quiet();

    // out-of-range register values are clamped
    write_config(0, 127, 0, 0, 0, 0, 0, 1);
    queue_conv(0, 63, 0, 0, 1'b1);
    queue_conv(1, 0, 0, 0, 1'b1);
    queue_conv(0, 0, 0, 1, 1'b1);
    wait_quiet();

    // kernel larger than the image in valid mode: no output exists
    write_config(3, 3, 31, 31, 5, 5, 15, 0);
    queue_conv(0, 0, 0, 0, 1'b1);
    wait_quiet();

    // even kernel sizes in same mode
    write_config(5, 6, 2, 2, 4, 2, 2, 1);
    queue_conv(0, 0, 0, 0, 1'b1);
    queue_conv(4, 5, 1, 1, 1'b1);
    queue_conv(2, 3, 1, 0, 1'b1);
    wait_quiet();

    // random phases, one of them and a share of the rest without gaps
    items_queued = 0;
    phase        = 0;
    while (items_queued < RANDOM_ITEMS) begin
      no_gaps = (phase == 2) || ($urandom_range(5) == 0);
      random_phase();
      phase++;
    end
    no_gaps = 1'b0;
    wait_quiet();

    if (mismatches == 0) begin
      $display("indexed_masked_conv2d_unit verification clean");
    end else begin
      $display("indexed_masked_conv2d_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
